// ===== hw/rtl/bitmap_page_frame_allocator_macros.svh =====
// Assertion macros for the bitmap page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error("bpfa same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error("bpfa next-cycle check failed");

`else

`define BPFA_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons)
`define BPFA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== hw/rtl/bpfa_pkg.sv =====
// Shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

    localparam int PG_SHIFT    = 12;
    localparam int WORD_BITS   = 32;
    localparam int ALLOC_FIRST = 256;
    localparam int FIRST_WORD  = ALLOC_FIRST / WORD_BITS;
    localparam logic [11:0] LOW_LIMIT_MB = 12'h001;  // address[31:20] of 1 MiB

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NONE_FREE  = 3'd1,
        ST_MISALIGNED = 3'd2,
        ST_BEYOND     = 3'd3,
        ST_LOW_MEM    = 3'd4,
        ST_ALREADY    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_KERNEL_START = 2'd0,
        CFG_KERNEL_END   = 2'd1,
        CFG_HEAP_START   = 2'd2,
        CFG_HEAP_END     = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_INIT_WR,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_FREE_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    latch_item;
        logic    idx_zero;
        logic    idx_first;
        logic    idx_inc;
        logic    clr_wr;
        logic    init_start;
        logic    init_wr;
        logic    rd_scan;
        logic    rd_page;
        logic    alloc_take;
        logic    free_take;
        logic    set_status;
        status_t status_code;
        logic    result_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        status_t    free_chk;
        logic       word_has_free;
        logic       page_bit_set;
        logic       idx_last;
        logic       out_busy;
    } stat_t;

endpackage

// ===== hw/rtl/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap page frame allocator.
//
// Requests arrive on the s_axis channel: an action (init, allocate, free) and
// a byte address used only by free. Each request gives exactly one result on
// m_axis: allocated page address, status code and the free-page count.
// Kernel and heap ranges are set through the cfg write port; the user is to set
// them only while idle, as the block has no check for it. An init request reads them.
// Work per request, from acceptance to the result register:
//   init   one bitmap word built and written per cycle
//   alloc  one memory read per word scanned from word 8
//   free   one read-modify-write of the page's word, if the address checks pass
// WORDS is PAGE_COUNT / 32 rounded up. A new request is taken in the cycle
// after the last result was placed in the output register.
// After reset the block runs a clearing pass over all WORDS words that marks every
// page used; s_axis_tready stays low during it, config writes still land.
// The count reads zero until the first init or the first free that clears a page.
// If the receiver stalls, the result holds in the output register; the next
// request is still accepted and worked, and waits at its end until the
// register frees up.
module bitmap_page_frame_allocator #(
    parameter int PAGE_COUNT = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] action, [33:2] address, [39:34] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [25:0] page_address, [28:26] status,
                                        // [43:29] free_count, [47:44] zero
);
    import bpfa_pkg::*;

    `include "bitmap_page_frame_allocator_macros.svh"

    cmd_t        cmd;
    stat_t       stat;
    logic [25:0] res_page;
    logic [2:0]  res_status;
    logic [14:0] res_count;

    bpfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpfa_datapath #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_action        (s_axis_tdata[1:0]),
        .in_address       (s_axis_tdata[33:2]),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_page_address (res_page),
        .out_status       (res_status),
        .out_free_count   (res_count),
        .cmd              (cmd),
        .stat             (stat)
    );

    assign m_axis_tdata = {4'd0, res_count, res_status, res_page};

    // one request at a time: busy right after acceptance
    `BPFA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // no request taken during the clearing pass
    `BPFA_ASSERT_SAME(a_no_accept_clear, clk, rst_n, cmd.clr_wr, !s_axis_tready)
    // allocation only takes a word that has a clear bit
    `BPFA_ASSERT_SAME(a_alloc_has_free, clk, rst_n, cmd.alloc_take, stat.word_has_free)
    // a free only clears a page that was marked used
    `BPFA_ASSERT_SAME(a_free_was_used, clk, rst_n, cmd.free_take, stat.page_bit_set)

endmodule

// ===== hw/rtl/bpfa_ctrl.sv =====
// Controller state machine of the bitmap page frame allocator.
module bpfa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bpfa_pkg::stat_t stat,
    output bpfa_pkg::cmd_t  cmd
);
    import bpfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.action)
                    ACT_INIT:  state_next = S_INIT_WR;
                    ACT_ALLOC: state_next = S_ALLOC_RD;
                    ACT_FREE:  state_next = (stat.free_chk == ST_OK) ? S_FREE_CHK : S_DONE;
                    default:   state_next = S_DONE;
                endcase
            end
            S_INIT_WR:
            begin
                if (stat.idx_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ALLOC_RD:
            begin
                state_next = S_ALLOC_CHK;
            end
            S_ALLOC_CHK:
            begin
                if (stat.word_has_free || stat.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ALLOC_RD;
                end
            end
            S_FREE_CHK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.status_code = ST_OK;
        in_ready    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.idx_zero = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.latch_item = in_valid;
            end
            S_DISPATCH:
            begin
                case (stat.action)
                    ACT_INIT:
                    begin
                        cmd.idx_zero   = 1'b1;
                        cmd.init_start = 1'b1;
                    end
                    ACT_ALLOC:
                    begin
                        cmd.idx_first = 1'b1;
                    end
                    ACT_FREE:
                    begin
                        if (stat.free_chk == ST_OK)
                        begin
                            cmd.rd_page = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = stat.free_chk;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b0;
                    end
                endcase
            end
            S_INIT_WR:
            begin
                cmd.init_wr = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.idx_zero = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_ALLOC_RD:
            begin
                cmd.rd_scan = 1'b1;
            end
            S_ALLOC_CHK:
            begin
                if (stat.word_has_free)
                begin
                    cmd.alloc_take = 1'b1;
                end
                else if (stat.idx_last)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NONE_FREE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_FREE_CHK:
            begin
                if (stat.page_bit_set)
                begin
                    cmd.free_take = 1'b1;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_ALREADY;
                end
            end
            S_DONE:
            begin
                cmd.result_load = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bpfa_datapath.sv =====
// Datapath of the bitmap page frame allocator: bitmap memory, counters, config and result.
module bpfa_datapath #(
    parameter int PAGE_COUNT = 16384
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_wdata,
    input  logic [1:0]      in_action,
    input  logic [31:0]     in_address,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [25:0]     out_page_address,
    output logic [2:0]      out_status,
    output logic [14:0]     out_free_count,
    input  bpfa_pkg::cmd_t  cmd,
    output bpfa_pkg::stat_t stat
);
    import bpfa_pkg::*;

    localparam int WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W = $clog2(WORDS);
    localparam int CNT_W = $clog2(PAGE_COUNT + 1);

    // bitmap memory, one bit per page, 1 = used
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr_reg;

    logic [31:0]      kstart_reg;
    logic [31:0]      kend_reg;
    logic [31:0]      hstart_reg;
    logic [31:0]      hend_reg;
    logic [1:0]       action_reg;
    logic [31:0]      addr_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    status_t          res_status_reg;
    logic [13:0]      res_page_reg;
    logic             out_valid_reg;
    logic [25:0]      out_page_reg;
    logic [2:0]       out_status_reg;
    logic [14:0]      out_cnt_reg;

    function automatic logic [5:0] range_off(input logic [20:0] lim, input logic [20:0] base);
        logic [20:0] top;
        logic [20:0] diff;
        top  = base + 21'd32;
        diff = lim - base;
        if (lim <= base)
        begin
            range_off = 6'd0;
        end
        else if (lim >= top)
        begin
            range_off = 6'd32;
        end
        else
        begin
            range_off = diff[5:0];
        end
    endfunction

    function automatic logic [31:0] range_mask(input logic [20:0] first, input logic [20:0] last,
                                               input logic [20:0] base);
        logic [32:0] lo_sh;
        logic [32:0] hi_sh;
        lo_sh = {33{1'b1}} << range_off(first, base);
        hi_sh = {33{1'b1}} << range_off(last, base);
        range_mask = lo_sh[31:0] & ~hi_sh[31:0];
    endfunction

    function automatic logic [20:0] first_page(input logic [31:0] a);
        first_page = {1'b0, a[31:PG_SHIFT]};
    endfunction

    function automatic logic [20:0] last_page(input logic [31:0] a);
        last_page = {1'b0, a[31:PG_SHIFT]} + {20'd0, |a[PG_SHIFT-1:0]};
    endfunction

    // init word: low pages (page zero, below 1 MiB), kernel, heap, padding
    logic [20:0] word_base;
    logic [31:0] init_word;
    logic [5:0]  init_free;
    assign word_base = 21'({idx_reg, 5'b0});

    always_comb
    begin
        init_word = range_mask(21'd0, 21'(ALLOC_FIRST), word_base)
                  | range_mask(first_page(kstart_reg), last_page(kend_reg), word_base)
                  | range_mask(first_page(hstart_reg), last_page(hend_reg), word_base)
                  | range_mask(21'(PAGE_COUNT), 21'h1F_FFFF, word_base);
        init_free = 6'd32 - 6'($countones(init_word));
    end

    // free checks on the latched address
    logic [20:0]      free_page;
    logic [IDX_W-1:0] free_word;
    logic [4:0]       free_bit_idx;
    status_t          free_chk;
    assign free_page    = {1'b0, addr_reg[31:PG_SHIFT]};
    assign free_word    = free_page[IDX_W+4:5];
    assign free_bit_idx = free_page[4:0];

    always_comb
    begin
        if (addr_reg[PG_SHIFT-1:0] != '0)
        begin
            free_chk = ST_MISALIGNED;
        end
        else if (free_page >= 21'(PAGE_COUNT))
        begin
            free_chk = ST_BEYOND;
        end
        else if (addr_reg[31:20] < LOW_LIMIT_MB)
        begin
            free_chk = ST_LOW_MEM;
        end
        else
        begin
            free_chk = ST_OK;
        end
    end

    // lowest clear bit of the word just read
    logic [4:0] zero_bit;
    always_comb
    begin
        zero_bit = 5'd0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!rd_data_reg[b])
            begin
                zero_bit = 5'(b);
            end
        end
    end

    logic [20:0] alloc_page;
    assign alloc_page = 21'({rd_addr_reg, zero_bit});

    // memory write and read ports
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '1;
        if (cmd.clr_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.init_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = init_word;
        end
        else if (cmd.alloc_take)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_reg;
            mem_wdata = rd_data_reg | (32'd1 << zero_bit);
        end
        else if (cmd.free_take)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_reg;
            mem_wdata = rd_data_reg & ~(32'd1 << free_bit_idx);
        end
        mem_re    = cmd.rd_scan | cmd.rd_page;
        mem_raddr = cmd.rd_page ? free_word : idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
            rd_addr_reg <= mem_raddr;
        end
    end

    // item, working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            action_reg   <= in_action;
            addr_reg     <= in_address;
            res_page_reg <= '0;
        end
        else if (cmd.alloc_take)
        begin
            res_page_reg <= alloc_page[13:0];
        end
        if (cmd.result_load)
        begin
            out_page_reg   <= {res_page_reg, 12'd0};
            out_status_reg <= res_status_reg;
            out_cnt_reg    <= 15'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kstart_reg     <= '0;
            kend_reg       <= '0;
            hstart_reg     <= '0;
            hend_reg       <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KERNEL_START: kstart_reg <= cfg_wdata;
                    CFG_KERNEL_END:   kend_reg   <= cfg_wdata;
                    CFG_HEAP_START:   hstart_reg <= cfg_wdata;
                    CFG_HEAP_END:     hend_reg   <= cfg_wdata;
                    default:          kstart_reg <= kstart_reg;
                endcase
            end

            if (cmd.idx_zero)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_first)
            begin
                idx_reg <= IDX_W'(FIRST_WORD);
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.init_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.init_wr)
            begin
                cnt_reg <= cnt_reg + CNT_W'(init_free);
            end
            else if (cmd.alloc_take)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else if (cmd.free_take)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.latch_item)
            begin
                res_status_reg <= ST_OK;
            end
            else if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end

            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.action        = action_reg;
    assign stat.free_chk      = free_chk;
    assign stat.word_has_free = ~&rd_data_reg;
    assign stat.page_bit_set  = rd_data_reg[free_bit_idx];
    assign stat.idx_last      = (idx_reg == IDX_W'(WORDS - 1));
    assign stat.out_busy      = out_valid_reg & ~out_ready;

    assign out_valid        = out_valid_reg;
    assign out_page_address = out_page_reg;
    assign out_status       = out_status_reg;
    assign out_free_count   = out_cnt_reg;

endmodule
